// ----- hdl/ipd_sc_pkg.sv -----
// shared widths, register indexes and clamp codes for the servo controller
// no dependencies; imported by the interfaces, the top level and the checker
package ipd_sc_pkg;

  localparam int unsigned SAMPLE_W   = 16;  // command error, position, velocity, drive
  localparam int unsigned GAIN_W     = 15;  // gains and drive limit
  localparam int unsigned ACC_W      = 32;  // integral accumulator
  localparam int unsigned FRAC_W     = 8;   // q7.8 gain scaling shift
  localparam int unsigned PROD_W     = SAMPLE_W + GAIN_W;  // 16s x 15u fits 31 bits signed
  localparam int unsigned CLAMP_W    = 2;
  localparam int unsigned CFG_ADDR_W = 2;
  localparam int unsigned CFG_DATA_W = GAIN_W;

  // register indexes
  localparam logic [CFG_ADDR_W-1:0] REG_INTEGRAL_GAIN = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_POSITION_GAIN = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_VELOCITY_GAIN = 2'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_DRIVE_LIMIT   = 2'd3;

  // clamp state codes
  localparam logic [CLAMP_W-1:0] CLAMP_NONE = 2'd0;
  localparam logic [CLAMP_W-1:0] CLAMP_HIGH = 2'd1;
  localparam logic [CLAMP_W-1:0] CLAMP_LOW  = 2'd2;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic [GAIN_W-1:0]          gain_t;
  typedef logic [CLAMP_W-1:0]         clamp_t;

endpackage

// ----- hdl/ipd_sc_if.sv -----
// valid/ready channel interfaces for the servo controller sample and result items
// depends on ipd_sc_pkg
interface ipd_sc_in_if;
  import ipd_sc_pkg::*;

  logic    valid;
  logic    ready;
  sample_t command_error;
  sample_t measured_position;
  sample_t measured_velocity;

  modport source (output valid, output command_error, output measured_position,
                  output measured_velocity, input ready);
  modport sink   (input valid, input command_error, input measured_position,
                  input measured_velocity, output ready);
endinterface

interface ipd_sc_out_if;
  import ipd_sc_pkg::*;

  logic    valid;
  logic    ready;
  sample_t drive;
  clamp_t  clamp_state;

  modport source (output valid, output drive, output clamp_state, input ready);
  modport sink   (input valid, input drive, input clamp_state, output ready);
endinterface

// ----- hdl/ipd_servo_controller.sv -----
// integral/position/velocity servo controller with anti-windup clamp
// depends on ipd_sc_pkg and the channel interfaces in ipd_sc_if.sv
// items go through the input register, then the result register; output stalls hold them
// one item per cycle unless stalled; the accumulator loop closes in the single compute stage
// reset (rst_n low, synchronous): gains, drive limit and accumulator cleared, both stages empty
module ipd_servo_controller (
  input  logic                                clk,
  input  logic                                rst_n,
  ipd_sc_in_if.sink                           in_ch,
  ipd_sc_out_if.source                        out_ch,
  input  logic                                cfg_we,
  input  logic [ipd_sc_pkg::CFG_ADDR_W-1:0]   cfg_addr,
  input  logic [ipd_sc_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
  import ipd_sc_pkg::*;

  // configuration registers
  gain_t ki_r, kp_r, kv_r, lim_r;

  // input stage
  logic    s1_valid_r;
  sample_t s1_err_r, s1_pos_r, s1_vel_r;

  // result stage
  logic    out_valid_r;
  sample_t out_drive_r;
  clamp_t  out_clamp_r;

  // integral state
  logic [ACC_W-1:0] acc_r;

  // handshake plumbing
  logic out_free;   // result register empty or being taken
  logic s1_move;    // input stage item passes into the result register
  logic in_take;

  // datapath
  logic signed [2*SAMPLE_W-1:0]     ie_full, p_full, v_full;
  logic signed [PROD_W-1:0]         ie_prod;
  logic signed [PROD_W-FRAC_W-1:0]  p_term, v_term;     // floor(prod / 256)
  logic [ACC_W-1:0]                 acc_sum;
  logic signed [ACC_W-FRAC_W-1:0]   acc_term;           // floor(acc_sum / 256)
  logic signed [ACC_W-FRAC_W+1:0]   raw_drive;          // room for both subtractions
  logic signed [ACC_W-FRAC_W+1:0]   lim_pos, lim_neg;
  logic signed [ACC_W-FRAC_W:0]     pv_sum, base_hi, base_lo;
  logic [ACC_W-1:0]                 acc_nxt;
  sample_t                          drive_nxt;
  clamp_t                           clamp_nxt;

  assign out_free     = !out_valid_r || out_ch.ready;
  assign s1_move      = s1_valid_r && out_free;
  assign in_ch.ready  = !s1_valid_r || out_free;
  assign in_take      = in_ch.valid && in_ch.ready;

  assign out_ch.valid       = out_valid_r;
  assign out_ch.drive       = out_drive_r;
  assign out_ch.clamp_state = out_clamp_r;

  // products: gains zero-extended to signed so the multiply stays signed
  assign ie_full = s1_err_r * $signed({1'b0, ki_r});
  assign p_full  = s1_pos_r * $signed({1'b0, kp_r});
  assign v_full  = s1_vel_r * $signed({1'b0, kv_r});

  assign ie_prod = ie_full[PROD_W-1:0];
  // arithmetic shift right by the fraction width: drop the low bits
  assign p_term  = p_full[PROD_W-1:FRAC_W];
  assign v_term  = v_full[PROD_W-1:FRAC_W];

  // accumulator wraps modulo 2^32
  assign acc_sum  = acc_r + {{(ACC_W-PROD_W){ie_prod[PROD_W-1]}}, ie_prod};
  assign acc_term = $signed(acc_sum[ACC_W-1:FRAC_W]);

  assign raw_drive = $signed({{2{acc_term[ACC_W-FRAC_W-1]}}, acc_term})
                   - $signed({{3{p_term[PROD_W-FRAC_W-1]}}, p_term})
                   - $signed({{3{v_term[PROD_W-FRAC_W-1]}}, v_term});

  assign lim_pos = $signed({{(ACC_W-FRAC_W+2-GAIN_W){1'b0}}, lim_r});
  assign lim_neg = -lim_pos;

  // anti-windup targets: accumulator rewritten to (p + v +/- limit) << 8
  assign pv_sum  = $signed({{2{p_term[PROD_W-FRAC_W-1]}}, p_term})
                 + $signed({{2{v_term[PROD_W-FRAC_W-1]}}, v_term});
  assign base_hi = pv_sum + $signed({{(ACC_W-FRAC_W+1-GAIN_W){1'b0}}, lim_r});
  assign base_lo = pv_sum - $signed({{(ACC_W-FRAC_W+1-GAIN_W){1'b0}}, lim_r});

  always_comb begin
    if (raw_drive > lim_pos) begin
      // clamped high
      drive_nxt = lim_pos[SAMPLE_W-1:0];
      clamp_nxt = CLAMP_HIGH;
      acc_nxt   = {base_hi[ACC_W-FRAC_W-1:0], {FRAC_W{1'b0}}};
    end else if (raw_drive < lim_neg) begin
      // clamped low
      drive_nxt = lim_neg[SAMPLE_W-1:0];
      clamp_nxt = CLAMP_LOW;
      acc_nxt   = {base_lo[ACC_W-FRAC_W-1:0], {FRAC_W{1'b0}}};
    end else begin
      // within limits: raw drive fits the sample width here
      drive_nxt = raw_drive[SAMPLE_W-1:0];
      clamp_nxt = CLAMP_NONE;
      acc_nxt   = acc_sum;
    end
  end

  // configuration writes; the 2-bit index covers every register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ki_r  <= '0;
      kp_r  <= '0;
      kv_r  <= '0;
      lim_r <= '0;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_INTEGRAL_GAIN: ki_r  <= cfg_wdata;
        REG_POSITION_GAIN: kp_r  <= cfg_wdata;
        REG_VELOCITY_GAIN: kv_r  <= cfg_wdata;
        REG_DRIVE_LIMIT:   lim_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // control: stage valids and accumulator
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      acc_r       <= '0;
    end else begin
      if (in_take) begin
        s1_valid_r <= 1'b1;
      end else if (s1_move) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_move) begin
        out_valid_r <= 1'b1;
        acc_r       <= acc_nxt;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_err_r <= in_ch.command_error;
      s1_pos_r <= in_ch.measured_position;
      s1_vel_r <= in_ch.measured_velocity;
    end
    if (s1_move) begin
      out_drive_r <= drive_nxt;
      out_clamp_r <= clamp_nxt;
    end
  end

endmodule

// ----- hdl/ipd_sc_checker.sv -----
// port-level checks for the servo controller, bound to the top level
// depends on ipd_sc_pkg and ipd_servo_controller
module ipd_sc_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input ipd_sc_pkg::sample_t           drive,
  input ipd_sc_pkg::clamp_t            clamp_state
);
  import ipd_sc_pkg::*;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(drive) && $stable(clamp_state))
    else $error("result changed while stalled");

  // input backpressure only when the result side is full and stalled
  a_ready_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_ready |-> out_valid && !out_ready)
    else $error("input stalled without output backpressure");

  // clamped high gives a non-negative drive
  a_clamp_high: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && clamp_state == CLAMP_HIGH |-> !drive[SAMPLE_W-1])
    else $error("clamped high with negative drive");

  // clamped low gives a non-positive drive
  a_clamp_low: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && clamp_state == CLAMP_LOW |-> drive[SAMPLE_W-1] || drive == '0)
    else $error("clamped low with positive drive");

  // no unused clamp code
  a_clamp_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> clamp_state == CLAMP_NONE || clamp_state == CLAMP_HIGH ||
                  clamp_state == CLAMP_LOW)
    else $error("invalid clamp state code");

endmodule

bind ipd_servo_controller ipd_sc_checker u_ipd_sc_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_ch.valid),
  .in_ready    (in_ch.ready),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .drive       (out_ch.drive),
  .clamp_state (out_ch.clamp_state)
);
